FILE: sv/stpq_pkg.sv
// Shared types and codes for the sorted timestamp priority queue.
// No dependencies; imported by stpq_ctrl and the top level.
`default_nettype none

package stpq_pkg;

    // Request codes carried in the input tuser field
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_POP    = 2'd1;
    localparam logic [1:0] REQ_FLUSH  = 2'd2;

    // Result status codes carried in the output tuser field
    localparam logic [1:0] STAT_DONE       = 2'd0;
    localparam logic [1:0] STAT_FULL       = 2'd1;
    localparam logic [1:0] STAT_NO_STAMP   = 2'd2;
    localparam logic [1:0] STAT_POP_EMPTY  = 2'd3;

    // Reserved value meaning "no timestamp"
    localparam logic [63:0] NO_STAMP = 64'h8000_0000_0000_0000;

    localparam int OCC_W = 12;

    // Controller sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CMP,
        S_UP_FIN,
        S_DN_START,
        S_DN_CMP,
        S_DN_FIN,
        S_DONE
    } state_t;

    // One request beat
    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] stamp_in;
    } req_t;

    // One result beat
    typedef struct packed {
        logic [1:0]       status;
        logic [63:0]      stamp_out;
        logic [OCC_W-1:0] occupancy;
    } res_t;

endpackage

`default_nettype wire

FILE: sv/stpq_ram.sv
// Heap storage: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none

module stpq_ram #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [63:0]   wdata,
    input  wire logic [AW-1:0] ra_addr,
    output logic      [63:0]   ra_data,
    input  wire logic [AW-1:0] rb_addr,
    output logic      [63:0]   rb_data
);

    logic [63:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read ports, registered read data
    always_ff @(posedge clk)
    begin
        ra_data <= mem[ra_addr];
        rb_data <= mem[rb_addr];
    end

endmodule

`default_nettype wire

FILE: sv/stpq_ctrl.sv
// Heap sequencer: sift-up on insert, sift-down on pop, flush, status.
// Depends on stpq_pkg; drives the ports of stpq_ram.
`default_nettype none

module stpq_ctrl
    import stpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2048,
    parameter int AW          = 11,
    parameter int CW          = 12
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire req_t          in_req,
    output logic               res_valid,
    input  wire logic          res_ready,
    output res_t               res,
    output logic               mem_we,
    output logic      [AW-1:0] mem_waddr,
    output logic      [63:0]   mem_wdata,
    output logic      [AW-1:0] mem_ra_addr,
    output logic      [AW-1:0] mem_rb_addr,
    input  wire logic [63:0]   mem_ra_data,
    input  wire logic [63:0]   mem_rb_data
);

    localparam int IW = CW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [63:0]     key_reg, key_next;     // inserted value, or last entry on pop
    logic [63:0]     head_reg, head_next;
    logic [1:0]      status_reg, status_next;

    logic [IW-1:0]   idx_ext, cnt_ext;
    logic [IW-1:0]   up_p1, up_p2, cnt_parent, cnt_minus1;
    logic [IW-1:0]   ch_l, ch_r, sel_c, sel_l, sel_r;
    logic            a_lt_last, b_lt_last, b_lt_a, use_b, l_ok, child_lt;
    logic [63:0]     child_val;
    logic [OCC_W+CW-1:0] occ_wide;

    // index arithmetic, widened so child indexes never wrap
    always_comb
    begin
        idx_ext    = {{(IW-AW){1'b0}}, idx_reg};
        cnt_ext    = {1'b0, count_reg};
        up_p1      = (idx_ext - IW'(1)) >> 1;
        up_p2      = (up_p1 - IW'(1)) >> 1;
        cnt_minus1 = cnt_ext - IW'(1);
        cnt_parent = cnt_minus1 >> 1;
        ch_l       = {idx_ext[IW-2:0], 1'b1};
        ch_r       = ch_l + IW'(1);
    end

    // sift-down child selection, compares in parallel
    always_comb
    begin
        b_lt_a    = $signed(mem_rb_data) < $signed(mem_ra_data);
        a_lt_last = $signed(mem_ra_data) < $signed(key_reg);
        b_lt_last = $signed(mem_rb_data) < $signed(key_reg);
        l_ok      = ch_l < cnt_ext;
        use_b     = (ch_r < cnt_ext) && b_lt_a;
        child_val = use_b ? mem_rb_data : mem_ra_data;
        child_lt  = use_b ? b_lt_last : a_lt_last;
        sel_c     = use_b ? ch_r : ch_l;
        sel_l     = {sel_c[IW-2:0], 1'b1};
        sel_r     = sel_l + IW'(1);
    end

    // state register and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        key_reg    <= key_next;
        head_reg   <= head_next;
        status_reg <= status_next;
    end

    // next state, memory access and handshake
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        key_next    = key_reg;
        head_next   = head_reg;
        status_next = status_reg;
        mem_we      = 1'b0;
        mem_waddr   = idx_reg;
        mem_wdata   = key_reg;
        mem_ra_addr = '0;
        mem_rb_addr = up_p2[AW-1:0];
        in_ready    = 1'b0;
        res_valid   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                mem_ra_addr = '0;
                mem_rb_addr = (in_req.req_type == REQ_POP) ? cnt_minus1[AW-1:0]
                                                            : cnt_parent[AW-1:0];
                if (in_valid)
                begin
                    key_next    = in_req.stamp_in;
                    head_next   = NO_STAMP;
                    status_next = STAT_DONE;
                    idx_next    = count_reg[AW-1:0];
                    state_next  = S_DONE;
                    case (in_req.req_type)
                        REQ_INSERT:
                        begin
                            if (in_req.stamp_in == NO_STAMP)
                                status_next = STAT_NO_STAMP;
                            else if (count_reg >= DEPTH_C)
                                status_next = STAT_FULL;
                            else if (count_reg == '0)
                                state_next = S_UP_FIN;
                            else
                                state_next = S_UP_CMP;
                        end
                        REQ_POP:
                        begin
                            if (count_reg == '0)
                                status_next = STAT_POP_EMPTY;
                            else
                                state_next = S_DN_START;
                        end
                        REQ_FLUSH:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            // unused code: no operation
                        end
                    endcase
                end
            end

            // rb_data holds the parent of idx_reg; grandparent read issued now
            S_UP_CMP:
            begin
                mem_rb_addr = up_p2[AW-1:0];
                if ($signed(mem_rb_data) > $signed(key_reg))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_reg;
                    mem_wdata = mem_rb_data;
                    idx_next  = up_p1[AW-1:0];
                    if (up_p1 == '0)
                        state_next = S_UP_FIN;
                end
                else
                begin
                    state_next = S_UP_FIN;
                end
            end

            S_UP_FIN:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                mem_wdata  = key_reg;
                count_next = count_reg + CW'(1);
                state_next = S_DONE;
            end

            // ra_data is the root, rb_data the last entry; read root's children
            S_DN_START:
            begin
                head_next   = mem_ra_data;
                key_next    = mem_rb_data;
                count_next  = count_reg - CW'(1);
                idx_next    = '0;
                mem_ra_addr = AW'(1);
                mem_rb_addr = AW'(IW'(2));
                state_next  = S_DN_CMP;
            end

            // ra/rb hold the children of idx_reg
            S_DN_CMP:
            begin
                mem_ra_addr = sel_l[AW-1:0];
                mem_rb_addr = sel_r[AW-1:0];
                if (l_ok && child_lt)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_reg;
                    mem_wdata = child_val;
                    idx_next  = sel_c[AW-1:0];
                end
                else
                begin
                    state_next = S_DN_FIN;
                end
            end

            S_DN_FIN:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                mem_wdata  = key_reg;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result, occupancy masked to the field width
    always_comb
    begin
        occ_wide      = {{OCC_W{1'b0}}, count_reg};
        res.status    = status_reg;
        res.stamp_out = head_reg;
        res.occupancy = occ_wide[OCC_W-1:0];
    end

    // count never exceeds the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("stored count above depth");

    // memory writes only during a sift
    a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_UP_CMP || state_reg == S_UP_FIN ||
                    state_reg == S_DN_CMP || state_reg == S_DN_FIN))
        else $error("memory write outside sift");

    // heap writes stay within the occupied region
    a_waddr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ({{(CW-AW){1'b0}}, mem_waddr} <= count_reg))
        else $error("heap write beyond occupancy");

    // a successful pop removes exactly one entry
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DN_START) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("pop did not decrement count");

    // no beat accepted while a sift runs
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == S_IDLE && !res_valid))
        else $error("ready outside idle");

endmodule

`default_nettype wire

FILE: sv/sorted_timestamp_priority_queue.sv
// Top level: stream ports, result register, heap sequencer and storage.
// Depends on stpq_pkg, stpq_ctrl and stpq_ram.
//
// Bounded min-priority queue of signed 64-bit timestamps, kept as a binary
// heap in a one-write, two-read memory. Every request beat on the s_axis
// channel (tuser = request code: insert, pop, flush) produces one result
// beat on m_axis (tuser = status, tdata = popped stamp and occupancy).
// Insert sifts the new value up one level per cycle; pop reads root and last
// entry, then sifts down one level per cycle with both children read at once.
// Flush, a rejected insert and an empty pop go from acceptance straight to
// the result; inserts and pops sift first, and a pop of a deep heap takes
// longest, as each level waits on the memory's registered read.
// s_axis_tready is high only while the sequencer is idle; the next request is
// taken while the last result still waits in the output register.
// Reset clears the occupancy to zero and leaves the memory contents alone.
// When m_axis_tready is low the result holds in the output register and the
// sequencer waits with its next result until the register frees up.
`default_nettype none

module sorted_timestamp_priority_queue
    import stpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2048
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // [63:0] stamp_in
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] req_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [79:0] m_axis_tdata,   // [63:0] stamp_out, [75:64] occupancy
    output logic      [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    req_t          in_req;
    res_t          res;
    logic          res_valid, res_ready;
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_ra_addr, mem_rb_addr;
    logic [63:0]   mem_wdata, mem_ra_data, mem_rb_data;
    logic          out_valid_reg, out_valid_next;
    res_t          out_reg;

    assign in_req.req_type = s_axis_tuser;
    assign in_req.stamp_in = s_axis_tdata;

    stpq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_req      (in_req),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_ra_addr (mem_ra_addr),
        .mem_rb_addr (mem_rb_addr),
        .mem_ra_data (mem_ra_data),
        .mem_rb_data (mem_rb_data)
    );

    stpq_ram #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .ra_addr (mem_ra_addr),
        .ra_data (mem_ra_data),
        .rb_addr (mem_rb_addr),
        .rb_data (mem_rb_data)
    );

    // output register handshake
    always_comb
    begin
        res_ready      = !out_valid_reg || m_axis_tready;
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
            out_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_reg.occupancy, out_reg.stamp_out};
    assign m_axis_tuser  = out_reg.status;

endmodule

`default_nettype wire

FILE: verif/tb_sorted_timestamp_priority_queue.sv
// Testbench for sorted_timestamp_priority_queue: directed corner requests, random
// request traffic and a deep fill and drain, all checked beat by beat against a
// sorted-queue predictor. Depends on stpq_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_sorted_timestamp_priority_queue
    import stpq_pkg::*;
();

    localparam int QUEUE_DEPTH = 2048;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 24;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_CHUNKS = 11;
    localparam int DEEP_FILL = 300;
    // Request code the block does not use; acts as a no-op
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = REQ_INSERT;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    // Idle knobs, switched per stretch of traffic
    logic        tx_gaps_on = 1'b0;
    logic        rx_stalls_on = 1'b0;
    int          rx_stall_left = 0;

    // Predictor state: stored stamps in ascending order
    logic signed [63:0] queued_stamps[$];
    // Results expected from the block, oldest first
    res_t        pending_results[$];

    int          mismatch_cnt = 0;
    int          result_idx = 0;
    int          idle_cycles = 0;

    always #4 clk = ~clk;

    sorted_timestamp_priority_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [63:0] stamp_in
        .s_axis_tuser  (s_axis_tuser),   // [1:0] req_type
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [63:0] stamp_out, [75:64] occupancy
        .m_axis_tuser  (m_axis_tuser)    // [1:0] status
    );

    // Idle length: mostly short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 8);
        return $urandom_range(20, 40);
    endfunction

    function automatic int tx_gap();
        if (!tx_gaps_on || $urandom_range(0, 99) < 55)
            return 0;
        return idle_len();
    endfunction

    // Random stamp, never the no-timestamp marker
    function automatic logic [63:0] rand_stamp();
        logic [63:0] s;
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 7))
            0, 1, 2: s = {$urandom, $urandom};
            3, 4:    s = 64'($urandom_range(0, 15)) - 64'd8;     // dense duplicates
            5:       s = 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
            6:       s = NO_STAMP + 64'($urandom_range(1, 4));
            default: s = {{32{w[31]}}, w};
        endcase
        if (s == NO_STAMP)
            s = '0;
        return s;
    endfunction

    // Apply one request to the sorted queue and return the result it causes
    function automatic res_t serve_request(logic [1:0] req, logic signed [63:0] stamp);
        res_t r;
        int   pos;
        int   occ;
        r.status    = STAT_DONE;
        r.stamp_out = NO_STAMP;
        case (req)
            REQ_INSERT:
            begin
                if (stamp == NO_STAMP)
                    r.status = STAT_NO_STAMP;
                else if (queued_stamps.size() >= QUEUE_DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    pos = queued_stamps.size();
                    while (pos > 0 && queued_stamps[pos-1] > stamp)
                        pos--;
                    queued_stamps.insert(pos, stamp);
                end
            end
            REQ_POP:
            begin
                if (queued_stamps.size() == 0)
                    r.status = STAT_POP_EMPTY;
                else
                    r.stamp_out = queued_stamps.pop_front();
            end
            REQ_FLUSH:
                queued_stamps.delete();
            default: ;
        endcase
        occ = queued_stamps.size();
        r.occupancy = occ[OCC_W-1:0];
        return r;
    endfunction

    // Result checker and request predictor, both at the sampling edge
    always @(posedge clk)
    begin : monitor
        res_t got;
        res_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status    = m_axis_tuser;
                got.stamp_out = m_axis_tdata[63:0];
                got.occupancy = m_axis_tdata[64 +: OCC_W];
                if (pending_results.size() == 0)
                begin
                    if (mismatch_cnt < MAX_REPORTS)
                        $display("ERROR: beat %0d unexpected: status %0d stamp %h occ %0d",
                                 result_idx, got.status, got.stamp_out, got.occupancy);
                    mismatch_cnt++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status || got.stamp_out !== want.stamp_out ||
                        got.occupancy !== want.occupancy)
                    begin
                        if (mismatch_cnt < MAX_REPORTS)
                        begin
                            $display("ERROR: beat %0d: expected status %0d stamp %h occ %0d",
                                     result_idx, want.status, want.stamp_out,
                                     want.occupancy);
                            $display("       got status %0d stamp %h occ %0d",
                                     got.status, got.stamp_out, got.occupancy);
                        end
                        mismatch_cnt++;
                    end
                end
                result_idx++;
            end
            if (s_axis_tvalid && s_axis_tready)
                pending_results.push_back(serve_request(s_axis_tuser, s_axis_tdata));
        end
    end

    // Result-side backpressure
    always @(posedge clk)
    begin
        if (rx_stall_left != 0)
        begin
            m_axis_tready <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end
        else if (rx_stalls_on && $urandom_range(0, 99) < 25)
        begin
            m_axis_tready <= 1'b0;
            rx_stall_left <= idle_len() - 1;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Watchdog: too long without any accepted beat
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ERROR: no beat accepted for %0d cycles", idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Send one request beat; returns at the edge where it is accepted
    task automatic issue_request(input logic [1:0] req, input logic [63:0] stamp);
        int gap;
        gap = tx_gap();
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= stamp;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Empty-queue cases, marker, extremes, duplicates and the unused code
    task automatic test_corner_requests();
        tx_gaps_on   <= 1'b1;
        rx_stalls_on <= 1'b1;
        issue_request(REQ_POP, '0);
        issue_request(REQ_FLUSH, '1);
        issue_request(REQ_UNUSED, 64'hAAAA_AAAA_AAAA_AAAA);
        issue_request(REQ_INSERT, NO_STAMP);
        issue_request(REQ_INSERT, 64'h7FFF_FFFF_FFFF_FFFF);
        issue_request(REQ_INSERT, NO_STAMP + 64'd1);
        issue_request(REQ_INSERT, 64'h0);
        issue_request(REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        issue_request(REQ_INSERT, 64'h0);
        issue_request(REQ_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
        issue_request(REQ_INSERT, 64'h5555_5555_5555_5555);
        issue_request(REQ_UNUSED, 64'h5555_5555_5555_5555);
        issue_request(REQ_POP, 64'h5555_5555_5555_5555);
        issue_request(REQ_POP, '0);
        issue_request(REQ_POP, '0);
        issue_request(REQ_POP, '0);
        issue_request(REQ_FLUSH, '0);
        issue_request(REQ_POP, '0);
        issue_request(REQ_INSERT, 64'h7FFF_FFFF_FFFF_FFFF);
        issue_request(REQ_INSERT, 64'h7FFF_FFFF_FFFF_FFFF);
        issue_request(REQ_POP, '0);
        issue_request(REQ_POP, '0);
        issue_request(REQ_POP, '0);
    endtask

    // Random mix in stretches that grow, drain or hold the queue
    task automatic test_random_traffic(input int n_chunks);
        int bias;
        int ins_lim;
        int r;
        for (int c = 0; c < n_chunks; c++)
        begin
            bias = $urandom_range(0, 2);
            ins_lim = (bias == 0) ? 70 : (bias == 1) ? 25 : 48;
            tx_gaps_on   <= ($urandom_range(0, 3) != 0);
            rx_stalls_on <= ($urandom_range(0, 3) != 0);
            for (int i = 0; i < 50; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < ins_lim)
                    issue_request(REQ_INSERT, rand_stamp());
                else if (r < 92)
                    issue_request(REQ_POP, {$urandom, $urandom});
                else if (r == 92)
                    issue_request(REQ_FLUSH, {$urandom, $urandom});
                else if (r < 96)
                    issue_request(REQ_UNUSED, {$urandom, $urandom});
                else
                    issue_request(REQ_INSERT, NO_STAMP);
            end
        end
    endtask

    // Grow a deep heap, then drain it completely in order and past empty
    task automatic test_deep_fill();
        tx_gaps_on   <= 1'b1;
        rx_stalls_on <= 1'b1;
        issue_request(REQ_FLUSH, '0);
        for (int i = 0; i < DEEP_FILL; i++)
            issue_request(REQ_INSERT, rand_stamp());
        issue_request(REQ_INSERT, NO_STAMP);
        issue_request(REQ_UNUSED, '1);
        for (int i = 0; i < DEEP_FILL + 2; i++)
            issue_request(REQ_POP, '0);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_corner_requests();
        test_random_traffic(RANDOM_CHUNKS);
        test_deep_fill();
        s_axis_tvalid <= 1'b0;
        // Let outstanding results come back, then watch for strays
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
